@@ rtl/core/fsbps_pkg.sv @@
// ----------------------------------------------------------------------------
// fsbps_pkg
// Shared sizes, register indexes, operation and pass codes, and the result
// word of the four-side boundary point scan.
// ----------------------------------------------------------------------------
`default_nettype none

package fsbps_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int SIZE_RESET     = 256;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_W'(1);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // pass codes; bit 0 selects the column table, bit 1 the descending walk
   localparam logic [2:0] PASS_LEFT   = 3'd0;
   localparam logic [2:0] PASS_TOP    = 3'd1;
   localparam logic [2:0] PASS_RIGHT  = 3'd2;
   localparam logic [2:0] PASS_BOTTOM = 3'd3;
   localparam logic [2:0] PASS_DONE   = 3'd4;

   typedef struct packed {
      logic [7:0] point_x;
      logic [7:0] point_y;
      logic [1:0] side;
      logic       point_valid;
      logic       last_point;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/fsbps_ram.sv @@
// ----------------------------------------------------------------------------
// fsbps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fsbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/four_side_boundary_point_scan.sv @@
// ----------------------------------------------------------------------------
// four_side_boundary_point_scan
// Load: a zero pixel writes nothing; a set one is read ahead, then written back.
// A frame's first pixel first runs a clear sweep over both tables and, when set,
// then reads its entries. Fetch: reads table entries in turn, changes pass, ends
// each seek on a hit or when the passes run out, over both seeks, and may wait on rsp_ready.
// Reset: runs the same clear sweep over both tables before taking words.
// ----------------------------------------------------------------------------
`default_nettype none

// Two RAMs hold the marks: the row table (found, first column, last column)
// and the column table (found, first row, last row). A load of a set pixel reads
// the row and column entry of the pixel, then writes the merged entry back. The
// next word is taken only after the write, so no forwarding is needed.
//
// A fetch walks a cursor over the tables, issuing one read a cycle but for pass
// changes and hits, and checking the returned found bit the cycle after. The first
// hit is the point; a second walk from just past it tells whether it is the last one.

module four_side_boundary_point_scan #(
   parameter int MAX_WIDTH  = fsbps_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fsbps_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_operation,
   input  wire logic [7:0]                       req_pixel_value,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [7:0]                       rsp_point_x,
   output logic      [7:0]                       rsp_point_y,
   output logic      [1:0]                       rsp_side,
   output logic                                  rsp_point_valid,
   output logic                                  rsp_last_point,

   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fsbps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fsbps_pkg::CSR_DATA_W-1:0]  csr_data
);

   import fsbps_pkg::*;

   localparam int XW      = $clog2(MAX_WIDTH);
   localparam int YW      = $clog2(MAX_HEIGHT);
   localparam int SWX     = $clog2(MAX_WIDTH + 1);
   localparam int SWY     = $clog2(MAX_HEIGHT + 1);
   localparam int DMAX    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int IW      = $clog2(DMAX + 1);
   localparam int CW      = $clog2(DMAX);
   localparam int RWW     = 1 + 2 * XW;
   localparam int CWW     = 1 + 2 * YW;
   localparam int RESET_W = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
   localparam int RESET_H = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_SEEK,
      ST_EMIT
   } state_type;

   // registers and their next values
   state_type        state_ff, state_in;
   logic [SWX-1:0]   width_ff, width_in;
   logic [SWY-1:0]   height_ff, height_in;
   logic [XW-1:0]    scan_x_ff, scan_x_in;
   logic [YW-1:0]    scan_y_ff, scan_y_in;
   logic [2:0]       fetch_pass_ff, fetch_pass_in;
   logic [IW-1:0]    fetch_index_ff, fetch_index_in;
   logic [2:0]       cur_pass_ff, cur_pass_in;
   logic [IW-1:0]    cur_idx_ff, cur_idx_in;
   logic             pend_v_ff, pend_v_in;
   logic [1:0]       pend_pass_ff, pend_pass_in;
   logic [IW-1:0]    pend_idx_ff, pend_idx_in;
   logic [YW-1:0]    pend_row_ff, pend_row_in;
   logic [XW-1:0]    pend_col_ff, pend_col_in;
   logic             second_ff, second_in;
   logic [CW-1:0]    clear_cnt_ff, clear_cnt_in;
   logic             load_pend_ff, load_pend_in;
   logic [XW-1:0]    ld_x_ff, ld_x_in;
   logic [YW-1:0]    ld_y_ff, ld_y_in;
   result_type       res_ff, res_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // handshakes
   logic req_fire, rsp_fire, csr_fire, pix_set;

   // table ports
   logic [YW-1:0]  row_rd_addr, row_wr_addr;
   logic [XW-1:0]  col_rd_addr, col_wr_addr;
   logic           row_we, col_we;
   logic [RWW-1:0] row_wr_data, row_rd, row_wr_load;
   logic [CWW-1:0] col_wr_data, col_rd, col_wr_load;

   // table fields
   logic           row_found, col_found;
   logic [XW-1:0]  row_first, row_last;
   logic [YW-1:0]  col_first, col_last;

   // scan and cursor helpers
   logic           x_last, y_last, scan_origin, clear_last;
   logic           cur_done, cur_end, pend_hit;
   logic [31:0]    n32, csr_val32, hit_x32, hit_y32;
   logic [YW-1:0]  seek_row;
   logic [XW-1:0]  seek_col;
   logic [SWX-1:0] width_clamped;
   logic [SWY-1:0] height_clamped;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign pix_set   = (req_pixel_value != 8'd0);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_ff.point_x;
   assign rsp_point_y     = rsp_ff.point_y;
   assign rsp_side        = rsp_ff.side;
   assign rsp_point_valid = rsp_ff.point_valid;
   assign rsp_last_point  = rsp_ff.last_point;

   // raster position
   assign x_last      = (32'(scan_x_ff) + 32'd1) >= 32'(width_ff);
   assign y_last      = (32'(scan_y_ff) + 32'd1) >= 32'(height_ff);
   assign scan_origin = (scan_x_ff == '0) && (scan_y_ff == '0);
   assign clear_last  = (32'(clear_cnt_ff) == 32'(DMAX - 1));

   // size clamp: zero becomes one, beyond the table depth becomes the depth
   assign csr_val32      = 32'(csr_data);
   assign width_clamped  = SWX'((csr_val32 == 32'd0) ? 32'd1 :
                               ((csr_val32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : csr_val32));
   assign height_clamped = SWY'((csr_val32 == 32'd0) ? 32'd1 :
                               ((csr_val32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : csr_val32));

   // cursor: odd passes walk the columns, passes two and three walk downward
   assign n32      = cur_pass_ff[0] ? 32'(width_ff) : 32'(height_ff);
   assign cur_done = cur_pass_ff[2];
   assign cur_end  = 32'(cur_idx_ff) >= n32;
   assign seek_row = YW'(cur_pass_ff[1] ? (32'(height_ff) - 32'd1 - 32'(cur_idx_ff))
                                        : 32'(cur_idx_ff));
   assign seek_col = XW'(cur_pass_ff[1] ? (32'(width_ff) - 32'd1 - 32'(cur_idx_ff))
                                        : 32'(cur_idx_ff));

   assign row_found = row_rd[RWW-1];
   assign row_first = row_rd[2*XW-1:XW];
   assign row_last  = row_rd[XW-1:0];
   assign col_found = col_rd[CWW-1];
   assign col_first = col_rd[2*YW-1:YW];
   assign col_last  = col_rd[YW-1:0];

   // check the entry read last cycle
   assign pend_hit = pend_v_ff && (pend_pass_ff[0] ? col_found : row_found);
   assign hit_x32  = pend_pass_ff[0] ? 32'(pend_col_ff)
                                     : (pend_pass_ff[1] ? 32'(row_last) : 32'(row_first));
   assign hit_y32  = pend_pass_ff[0] ? (pend_pass_ff[1] ? 32'(col_last) : 32'(col_first))
                                     : 32'(pend_row_ff);

   // merge a set pixel into its row and column entry
   assign row_wr_load = {1'b1, (row_found ? row_first : ld_x_ff), ld_x_ff};
   assign col_wr_load = {1'b1, (col_found ? col_first : ld_y_ff), ld_y_ff};

   always_comb begin
      row_rd_addr = seek_row;
      col_rd_addr = seek_col;
      row_we      = 1'b0;
      col_we      = 1'b0;
      row_wr_addr = ld_y_ff;
      col_wr_addr = ld_x_ff;
      row_wr_data = row_wr_load;
      col_wr_data = col_wr_load;
      case (state_ff)
         ST_IDLE: begin
            // read ahead for a load taken this cycle
            row_rd_addr = scan_y_ff;
            col_rd_addr = scan_x_ff;
         end
         ST_LOAD_RD: begin
            row_rd_addr = ld_y_ff;
            col_rd_addr = ld_x_ff;
         end
         ST_CLEAR: begin
            row_we      = 32'(clear_cnt_ff) < 32'(MAX_HEIGHT);
            col_we      = 32'(clear_cnt_ff) < 32'(MAX_WIDTH);
            row_wr_addr = clear_cnt_ff[YW-1:0];
            col_wr_addr = clear_cnt_ff[XW-1:0];
            row_wr_data = '0;
            col_wr_data = '0;
         end
         ST_LOAD_WR: begin
            row_we = 1'b1;
            col_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      scan_x_in      = scan_x_ff;
      scan_y_in      = scan_y_ff;
      fetch_pass_in  = fetch_pass_ff;
      fetch_index_in = fetch_index_ff;
      cur_pass_in    = cur_pass_ff;
      cur_idx_in     = cur_idx_ff;
      pend_v_in      = pend_v_ff;
      pend_pass_in   = pend_pass_ff;
      pend_idx_in    = pend_idx_ff;
      pend_row_in    = pend_row_ff;
      pend_col_in    = pend_col_ff;
      second_in      = second_ff;
      clear_cnt_in   = clear_cnt_ff;
      load_pend_in   = load_pend_ff;
      ld_x_in        = ld_x_ff;
      ld_y_in        = ld_y_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;

      // drop the result word once taken
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + CW'(1);
            if (clear_last) begin
               clear_cnt_in = '0;
               load_pend_in = 1'b0;
               state_in     = load_pend_ff ? ST_LOAD_RD : ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               if (req_operation == OP_LOAD) begin
                  ld_x_in = scan_x_ff;
                  ld_y_in = scan_y_ff;
                  // advance the raster position, wrapping at the frame end
                  if (x_last) begin
                     scan_x_in = '0;
                     scan_y_in = y_last ? '0 : (scan_y_ff + YW'(1));
                  end else begin
                     scan_x_in = scan_x_ff + XW'(1);
                  end
                  if (scan_origin) begin
                     // new frame: wipe the marks, rewind the fetch cursor
                     fetch_pass_in  = PASS_LEFT;
                     fetch_index_in = '0;
                     clear_cnt_in   = '0;
                     load_pend_in   = pix_set;
                     state_in       = ST_CLEAR;
                  end else if (pix_set) begin
                     state_in = ST_LOAD_WR;
                  end
               end else begin
                  cur_pass_in = fetch_pass_ff;
                  cur_idx_in  = fetch_index_ff;
                  pend_v_in   = 1'b0;
                  second_in   = 1'b0;
                  state_in    = ST_SEEK;
               end
            end
         end

         ST_LOAD_RD: begin
            state_in = ST_LOAD_WR;
         end

         ST_LOAD_WR: begin
            state_in = ST_IDLE;
         end

         ST_SEEK: begin
            if (pend_hit) begin
               pend_v_in = 1'b0;
               if (!second_ff) begin
                  // found the point; look past it for another one
                  res_in.point_x     = hit_x32[7:0];
                  res_in.point_y     = hit_y32[7:0];
                  res_in.side        = pend_pass_ff;
                  res_in.point_valid = 1'b1;
                  res_in.last_point  = 1'b0;
                  fetch_pass_in      = {1'b0, pend_pass_ff};
                  fetch_index_in     = pend_idx_ff + IW'(1);
                  cur_pass_in        = {1'b0, pend_pass_ff};
                  cur_idx_in         = pend_idx_ff + IW'(1);
                  second_in          = 1'b1;
               end else begin
                  res_in.last_point = 1'b0;
                  state_in          = ST_EMIT;
               end
            end else if (cur_done && !pend_v_ff) begin
               if (!second_ff) begin
                  // nothing left: empty word, cursor stays done
                  res_in         = '0;
                  fetch_pass_in  = PASS_DONE;
                  fetch_index_in = '0;
               end else begin
                  res_in.last_point = 1'b1;
               end
               state_in = ST_EMIT;
            end else if (cur_done) begin
               pend_v_in = 1'b0;
            end else if (cur_end) begin
               cur_idx_in  = '0;
               cur_pass_in = cur_pass_ff + 3'd1;
               pend_v_in   = 1'b0;
            end else begin
               pend_v_in    = 1'b1;
               pend_pass_in = cur_pass_ff[1:0];
               pend_idx_in  = cur_idx_ff;
               pend_row_in  = seek_row;
               pend_col_in  = seek_col;
               cur_idx_in   = cur_idx_ff + IW'(1);
            end
         end

         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a size write also rewinds the raster position
      if (csr_fire) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in  = width_clamped;
               scan_x_in = '0;
               scan_y_in = '0;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = height_clamped;
               scan_x_in = '0;
               scan_y_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         width_ff       <= SWX'(RESET_W);
         height_ff      <= SWY'(RESET_H);
         scan_x_ff      <= '0;
         scan_y_ff      <= '0;
         fetch_pass_ff  <= PASS_LEFT;
         fetch_index_ff <= '0;
         cur_pass_ff    <= PASS_LEFT;
         cur_idx_ff     <= '0;
         pend_v_ff      <= 1'b0;
         second_ff      <= 1'b0;
         clear_cnt_ff   <= '0;
         load_pend_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         scan_x_ff      <= scan_x_in;
         scan_y_ff      <= scan_y_in;
         fetch_pass_ff  <= fetch_pass_in;
         fetch_index_ff <= fetch_index_in;
         cur_pass_ff    <= cur_pass_in;
         cur_idx_ff     <= cur_idx_in;
         pend_v_ff      <= pend_v_in;
         second_ff      <= second_in;
         clear_cnt_ff   <= clear_cnt_in;
         load_pend_ff   <= load_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pend_pass_ff <= pend_pass_in;
      pend_idx_ff  <= pend_idx_in;
      pend_row_ff  <= pend_row_in;
      pend_col_ff  <= pend_col_in;
      ld_x_ff      <= ld_x_in;
      ld_y_ff      <= ld_y_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   fsbps_ram #(
      .WIDTH (RWW),
      .DEPTH (MAX_HEIGHT)
   ) u_row_table (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd)
   );

   fsbps_ram #(
      .WIDTH (CWW),
      .DEPTH (MAX_WIDTH)
   ) u_col_table (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (col_wr_addr),
      .wr_data (col_wr_data),
      .rd_addr (col_rd_addr),
      .rd_data (col_rd)
   );

endmodule

`default_nettype wire
